>>> hw/rtl/canonical_huffman_bit_decoder_macros.svh
// ============================================================================
// Canonical Huffman bit decoder assertion macros
// Short forms for clocked assertions that share the clk and rst_n of the scope.
// ============================================================================
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_MACROS_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/chd_pkg.sv
// ============================================================================
// Canonical Huffman bit decoder package
// Shared constants, function and status codes, and payload types.
// ============================================================================
package chd_pkg;

    localparam int CHD_MAX_CODE_LEN  = 24;
    localparam int CHD_ALPHABET_SIZE = 256;
    localparam int CHD_STORE_DEPTH   = 256;
    localparam int CHD_SYM_W         = 8;
    localparam int CHD_LEN_W         = 5;
    localparam int CHD_CNT_W         = 9;
    localparam int CHD_QUEUE_DEPTH   = 2;
    localparam int CHD_RESET_LEN     = 8;
    localparam int CHD_RESET_COUNT   = 256;

    localparam logic [1:0] FUNC_BEGIN = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_BIT   = 2'd2;

    localparam logic [1:0] ST_SYMBOL   = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_BADLEN   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        OP_BEGIN = 3'b001,
        OP_LOAD  = 3'b010,
        OP_BIT   = 3'b100
    } op_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [CHD_SYM_W-1:0] symbol;
        logic [CHD_LEN_W-1:0] code_length;
        logic                 bit_req;
    } item_t;

    typedef struct packed {
        logic [CHD_SYM_W-1:0] decoded_symbol;
        logic [1:0]           status;
    } result_t;

    typedef struct packed {
        op_t                  op;
        logic [CHD_SYM_W-1:0] symbol;
        logic [CHD_LEN_W-1:0] code_length;
        logic                 bit_req;
        logic                 len_range_bad;
    } cmd_t;

endpackage

>>> hw/rtl/chd_if.sv
// ============================================================================
// Canonical Huffman bit decoder stream interfaces
// Valid/ready channels for input items and for result items.
// ============================================================================
interface chd_item_if;
    import chd_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface chd_result_if;
    import chd_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/chd_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/chd_front.sv
// ============================================================================
// Canonical Huffman bit decoder front end
// Accepts input items, drops unused function codes and classifies the rest.
// ============================================================================
module chd_front
    import chd_pkg::*;
#(
    parameter int MAX_CODE_LEN = CHD_MAX_CODE_LEN
) (
    chd_item_if.sink items,
    output logic     push_valid,
    output cmd_t     push_cmd,
    input  logic     push_ready
);

    logic keep;
    op_t  op;

    always_comb
    begin
        keep = 1'b1;
        op   = OP_BEGIN;
        case (items.payload.func)
            FUNC_BEGIN: op = OP_BEGIN;
            FUNC_LOAD:  op = OP_LOAD;
            FUNC_BIT:   op = OP_BIT;
            default:    keep = 1'b0;
        endcase
    end

    // The range check of a load length needs no table state, so it is done here.
    always_comb
    begin
        push_cmd.op            = op;
        push_cmd.symbol        = items.payload.symbol;
        push_cmd.code_length   = items.payload.code_length;
        push_cmd.bit_req       = items.payload.bit_req;
        push_cmd.len_range_bad = (items.payload.code_length == '0)
            || (int'(items.payload.code_length) > MAX_CODE_LEN);
    end

    assign push_valid  = items.valid && keep;
    assign items.ready = push_ready;

endmodule

>>> hw/rtl/chd_queue.sv
// ============================================================================
// Canonical Huffman bit decoder command queue
// Short FIFO of classified commands between the front end and the back end.
// ============================================================================
module chd_queue
    import chd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop_ready
);

    localparam int DEPTH = CHD_QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/chd_back.sv
// ============================================================================
// Canonical Huffman bit decoder back end
// Builds the per-length code tables, decodes bits and delivers results.
// ============================================================================
module chd_back
    import chd_pkg::*;
#(
    parameter int MAX_CODE_LEN = CHD_MAX_CODE_LEN
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    input  cmd_t       pop_cmd,
    output logic       pop_ready,
    chd_result_if.source results
);

    localparam int LW = $clog2(MAX_CODE_LEN);
    localparam int CW = MAX_CODE_LEN + 1;
    localparam int AW = $clog2(CHD_STORE_DEPTH);
    localparam int IW = CHD_CNT_W;
    localparam int DW = (MAX_CODE_LEN > CHD_CNT_W) ? MAX_CODE_LEN : CHD_CNT_W;

    // Per-length tables; entry i describes codes of length i + 1.
    logic [MAX_CODE_LEN-1:0] first_code_reg  [MAX_CODE_LEN];
    logic [IW-1:0]           first_index_reg [MAX_CODE_LEN];
    logic [CHD_CNT_W-1:0]    count_reg       [MAX_CODE_LEN];

    logic [MAX_CODE_LEN-1:0] pcode_reg;
    logic [LW-1:0]           plen_reg;
    logic [CW-1:0]           next_code_reg;
    logic [CHD_LEN_W-1:0]    load_len_reg;
    logic [IW-1:0]           load_index_reg;
    logic [CHD_STORE_DEPTH-1:0] written_reg;

    logic                 p1_valid_reg;
    logic [1:0]           p1_status_reg;
    logic                 p1_from_ram_reg;
    logic                 p1_hit_reg;
    logic [AW-1:0]        p1_idx_reg;
    logic                 out_valid_reg;
    result_t              out_payload_reg;

    logic                    p1_move, p1_free, pop;
    logic [CHD_LEN_W-1:0]    lidx_full;
    logic [LW-1:0]           tidx;
    logic                    t_ok;
    logic [MAX_CODE_LEN-1:0] t_first;
    logic [IW-1:0]           t_first_index;
    logic [CHD_CNT_W-1:0]    t_count;

    logic [CHD_LEN_W-1:0]    shift;
    logic [CW-1:0]           code;
    logic                    load_bad, load_ovf, load_ok;

    logic [MAX_CODE_LEN-1:0] pc_new;
    logic [MAX_CODE_LEN:0]   diff;
    logic                    match, last_len;
    logic [AW-1:0]           ridx;

    logic                    res_valid;
    logic [1:0]              res_status;
    logic                    res_from_ram;
    logic                    ram_we, ram_re;
    logic [CHD_SYM_W-1:0]    ram_rdata;

    assign p1_move   = p1_valid_reg && (!out_valid_reg || results.ready);
    assign p1_free   = !p1_valid_reg || p1_move;
    assign pop_ready = p1_free;
    assign pop       = pop_valid && p1_free;

    // One table read per command: the load length, or the next bit's length.
    assign lidx_full = pop_cmd.code_length - CHD_LEN_W'(1);
    assign tidx      = (pop_cmd.op == OP_LOAD) ? lidx_full[LW-1:0] : plen_reg;
    assign t_ok      = int'(tidx) < MAX_CODE_LEN;
    assign t_first       = t_ok ? first_code_reg[tidx]  : '0;
    assign t_first_index = t_ok ? first_index_reg[tidx] : '0;
    assign t_count       = t_ok ? count_reg[tidx]       : '0;

    // Load: the new code is the running code widened to the new length.
    assign shift    = pop_cmd.code_length - load_len_reg;
    assign code     = next_code_reg << shift;
    assign load_bad = pop_cmd.len_range_bad || (pop_cmd.code_length < load_len_reg);
    assign load_ovf = ((code >> pop_cmd.code_length) != '0)
        || (load_index_reg >= IW'(CHD_ALPHABET_SIZE))
        || t_count[CHD_CNT_W-1];
    assign load_ok  = !load_bad && !load_ovf;

    // Bit: the extended partial code matches when it lies in its length's range.
    assign pc_new   = {pcode_reg[MAX_CODE_LEN-2:0], pop_cmd.bit_req};
    assign diff     = {1'b0, pc_new} - {1'b0, t_first};
    assign match    = (t_count != '0) && !diff[MAX_CODE_LEN]
        && (DW'(diff[MAX_CODE_LEN-1:0]) < DW'(t_count));
    assign last_len = (plen_reg == LW'(MAX_CODE_LEN - 1));
    assign ridx     = t_first_index[AW-1:0] + diff[AW-1:0];

    always_comb
    begin
        res_valid    = 1'b0;
        res_status   = ST_SYMBOL;
        res_from_ram = 1'b0;
        case (pop_cmd.op)
            OP_LOAD:
            begin
                if (load_bad)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_BADLEN;
                end
                else if (load_ovf)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_OVERFLOW;
                end
            end
            OP_BIT:
            begin
                if (match)
                begin
                    res_valid    = 1'b1;
                    res_from_ram = 1'b1;
                end
                else if (last_len)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_INVALID;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign ram_we = pop && (pop_cmd.op == OP_LOAD) && load_ok;
    assign ram_re = pop && (pop_cmd.op == OP_BIT) && match;

    chd_ram #(
        .WIDTH (CHD_SYM_W),
        .DEPTH (CHD_STORE_DEPTH)
    ) u_symbol_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_index_reg[AW-1:0]),
        .wdata (pop_cmd.symbol),
        .re    (ram_re),
        .raddr (ridx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CODE_LEN; i++)
            begin
                first_code_reg[i]  <= '0;
                first_index_reg[i] <= '0;
                count_reg[i]       <= (i == CHD_RESET_LEN - 1) ?
                    CHD_CNT_W'(CHD_RESET_COUNT) : '0;
            end
            pcode_reg      <= '0;
            plen_reg       <= '0;
            next_code_reg  <= '0;
            load_len_reg   <= '0;
            load_index_reg <= '0;
            written_reg    <= '0;
        end
        else if (pop)
        begin
            case (pop_cmd.op)
                OP_BEGIN:
                begin
                    for (int i = 0; i < MAX_CODE_LEN; i++)
                    begin
                        first_code_reg[i]  <= '0;
                        first_index_reg[i] <= '0;
                        count_reg[i]       <= '0;
                    end
                    pcode_reg      <= '0;
                    plen_reg       <= '0;
                    next_code_reg  <= '0;
                    load_len_reg   <= '0;
                    load_index_reg <= '0;
                end
                OP_LOAD:
                begin
                    if (load_ok)
                    begin
                        if (t_count == '0)
                        begin
                            first_code_reg[tidx]  <= code[MAX_CODE_LEN-1:0];
                            first_index_reg[tidx] <= load_index_reg;
                        end
                        count_reg[tidx] <= t_count + 1'b1;
                        written_reg[load_index_reg[AW-1:0]] <= 1'b1;
                        load_index_reg <= load_index_reg + 1'b1;
                        next_code_reg  <= code + 1'b1;
                        load_len_reg   <= pop_cmd.code_length;
                    end
                end
                OP_BIT:
                begin
                    if (match || last_len)
                    begin
                        pcode_reg <= '0;
                        plen_reg  <= '0;
                    end
                    else
                    begin
                        pcode_reg <= pc_new;
                        plen_reg  <= plen_reg + 1'b1;
                    end
                end
                default:
                begin
                    plen_reg <= plen_reg;
                end
            endcase
        end
    end

    // Read stage: the symbol store answers in the cycle after the lookup.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            p1_valid_reg <= res_valid;
        end
        else if (p1_move)
        begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p1_status_reg   <= res_status;
            p1_from_ram_reg <= res_from_ram;
            p1_idx_reg      <= ridx;
        end
        if (ram_re)
        begin
            p1_hit_reg <= written_reg[ridx];
        end
    end

    // Output register; a store entry never loaded yields its own index as the symbol.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (p1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            out_payload_reg.status <= p1_status_reg;
            if (p1_from_ram_reg)
            begin
                out_payload_reg.decoded_symbol <= p1_hit_reg ? ram_rdata : p1_idx_reg;
            end
            else
            begin
                out_payload_reg.decoded_symbol <= '0;
            end
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_payload_reg;

endmodule

>>> hw/rtl/canonical_huffman_bit_decoder.sv
// ============================================================================
// Canonical Huffman bit decoder
// Builds a canonical code table from (symbol, length) loads and decodes a
// bitstream one bit per item into byte symbols.
// ============================================================================
// The items channel takes begin, load and data-bit items; the results channel
// gives at most one result per item: a decoded symbol or a status code.
// A transfer happens on a clock edge with valid and ready both high.
// Throughput is one item per cycle when nothing stalls. A result passes from the
// transfer of its item through the command queue and table stage, then the
// symbol store read stage, into the output register.
// Items that cause no result, and the unused function code, pass silently.
// A stalled receiver holds the result in the output register; the read stage
// and a two-entry command queue then fill, after which items are refused.
// Reset (rst_n low) restores the default table, all 256 symbols as 8-bit
// identity codes, and empties the queue and pipeline. It needs no sweep.
// ============================================================================
module canonical_huffman_bit_decoder
    import chd_pkg::*;
#(
    parameter int MAX_CODE_LEN = CHD_MAX_CODE_LEN
) (
    input  logic         clk,
    input  logic         rst_n,
    chd_item_if.sink     items,
    chd_result_if.source results
);

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    chd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .items      (items),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    chd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    chd_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready),
        .results   (results)
    );

endmodule

>>> hw/rtl/chd_checker.sv
// ============================================================================
// Canonical Huffman bit decoder port checker
// Watches the top-level channels and flags results that break the contract.
// ============================================================================
`include "canonical_huffman_bit_decoder_macros.svh"

module chd_checker
    import chd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_payload
);

    localparam int CRW = 16;

    logic           in_xfer, out_xfer;
    logic [CRW-1:0] credit_reg, credit_next;
    logic           sat_reg, sat_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Each result belongs to an earlier input transfer; count the ones still open.
    always_comb
    begin
        credit_next = credit_reg;
        sat_next    = sat_reg;
        if (in_xfer && !out_xfer)
        begin
            if (credit_reg == '1)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                credit_next = credit_reg + 1'b1;
            end
        end
        else if (out_xfer && !in_xfer && credit_reg != '0)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            sat_reg    <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            sat_reg    <= sat_next;
        end
    end

    `CHD_ASSERT_NEXT(a_out_valid_held, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `CHD_ASSERT_NEXT(a_out_payload_held, out_valid && !out_ready, $stable(out_payload), "result changed while stalled")
    `CHD_ASSERT_IMPLY(a_status_symbol_zero, out_valid && out_payload.status != ST_SYMBOL, out_payload.decoded_symbol == '0, "error result carries a symbol")
    `CHD_ASSERT_IMPLY(a_no_spare_result, out_xfer, sat_reg || credit_reg != '0, "result without an open input transfer")

endmodule

bind canonical_huffman_bit_decoder chd_checker u_chd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_payload (results.payload)
);
